// ===== rtl/sfha_pkg.sv =====
// ============================================================================
// Segregated-fit heap allocator package
// Shared constants, header and command types, and class helper functions.
// ============================================================================
package sfha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int SIZE_CLASSES = 32;

    localparam int WORDS      = HEAP_BYTES / 4;
    localparam int WI         = $clog2(WORDS);
    localparam int LW         = WI + 1;
    localparam int LEN_W      = WI + 3;
    localparam int CL_W       = $clog2(SIZE_CLASSES);
    localparam int FC_W       = WI + 5;
    localparam int HDR_WORDS  = 3;
    localparam int MIN_WORDS  = 5;
    localparam int HDR_BYTES  = 12;
    localparam int MIN_BYTES  = 20;
    localparam int LAST_W     = WORDS - MIN_WORDS;
    localparam int END_OFF    = WORDS * 4;
    localparam int LAST_OFF   = END_OFF - MIN_BYTES;
    localparam int INIT_LEN   = (LAST_W - MIN_WORDS) * 4 - HDR_BYTES;
    localparam int FB_MAX     = 131071;

    typedef logic [WI-1:0] t_widx;
    typedef logic [LW-1:0] t_link;

    // One chunk header: address neighbours, free-list links (0 none, else index + 1).
    typedef struct packed {
        t_widx nxt;
        t_widx prv;
        t_link fnext;
        t_link fprev;
        logic  live;
        logic  used;
    } t_hdr;

    typedef enum logic [1:0] {K_QUERY, K_ALLOC, K_FREE, K_FAIL} t_kind;

    // Classified word handed from the front end to the back end.
    typedef struct packed {
        t_kind       kind;
        logic [5:0]  cls;
        logic [30:0] size_w;
        t_widx       off_w;
    } t_cmd;

    typedef struct packed {
        logic [31:0] addr;
        logic        status;
        logic [16:0] fb;
    } t_res;

    typedef enum logic [1:0] {F_PRV, F_FNEXT, F_FPREV} t_fld;

    typedef enum logic [4:0] {
        S_IDLE, S_ALC_FIND, S_ALC_RD, S_ALC_LD, S_ALC_SPLIT, S_ALC_PUSH, S_ALC_DONE,
        S_UL0, S_UL1, S_PU0, S_PU1, S_RMW_RD, S_RMW_WR,
        S_FR_RD, S_FR_CHK, S_FR_XRD, S_FR_XCHK, S_FR_XM,
        S_FR_PRD, S_FR_PCHK, S_FR_PM, S_FR_PPUSH, S_DONE
    } t_state;

    // Bit length of v, which is floor(log2 v) + 1 for nonzero v.
    function automatic logic [5:0] f_bitlen(input logic [32:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 33; i++) begin
            if (v[i]) begin
                r = 6'(i + 1);
            end
        end
        return r;
    endfunction

    // Free-list class of a chunk length, capped at the top class.
    function automatic logic [CL_W-1:0] f_list_class(input logic [LEN_W-1:0] len);
        int n;
        n = 0;
        for (int i = 0; i < LEN_W; i++) begin
            if (len[i]) begin
                n = i;
            end
        end
        if (n >= SIZE_CLASSES) begin
            n = SIZE_CLASSES - 1;
        end
        return CL_W'(n);
    endfunction

    localparam logic [CL_W-1:0] INIT_CLASS = f_list_class(LEN_W'(INIT_LEN));
    localparam int              INIT_FC    = INIT_LEN - HDR_BYTES;

    // Headers of the three chunks laid out at reset.
    function automatic t_hdr f_init_hdr(input logic [1:0] which);
        t_hdr h;
        h = '0;
        h.live = 1'b1;
        case (which)
            2'd0: begin
                h.nxt  = WI'(MIN_WORDS);
                h.prv  = WI'(LAST_W);
                h.used = 1'b1;
            end
            2'd1: begin
                h.nxt  = WI'(LAST_W);
                h.prv  = '0;
                h.used = 1'b0;
            end
            default: begin
                h.nxt  = '0;
                h.prv  = WI'(MIN_WORDS);
                h.used = 1'b1;
            end
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/sfha_front.sv =====
// ============================================================================
// Allocator front end
// Accepts request words, classifies them and queues them for the back end.
// ============================================================================
module sfha_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_operation,
    input  logic [31:0]         i_request_bytes,
    input  logic [31:0]         i_block_address,
    input  logic [31:0]         i_heap_base,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop,
    output sfha_pkg::t_cmd      o_cmd
);
    import sfha_pkg::*;

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    logic [32:0] size_b;
    logic [32:0] size_r;
    logic [5:0]  start_cls;
    logic [31:0] off_b;
    logic        free_ok;
    t_cmd        cls_cmd;
    logic        do_push;
    logic        do_pop;

    always_comb begin
        size_r  = ({1'b0, i_request_bytes} + 33'd3) & ~33'd3;
        size_b  = (size_r < 33'd8) ? 33'd8 : size_r;
        start_cls = f_bitlen(size_b - 33'd1);
        off_b   = i_block_address - i_heap_base - 32'(HDR_BYTES);
        free_ok = (i_block_address != 32'd0) && (off_b < 32'(END_OFF)) &&
                  (off_b[1:0] == 2'b00) && (off_b != 32'd0) &&
                  (off_b != 32'(LAST_OFF));

        cls_cmd        = '0;
        cls_cmd.cls    = start_cls;
        cls_cmd.size_w = size_b[32:2];
        cls_cmd.off_w  = off_b[WI+1:2];
        case (i_operation)
            2'd0: begin
                if (i_request_bytes == 32'd0 || start_cls >= 6'(SIZE_CLASSES)) begin
                    cls_cmd.kind = K_FAIL;
                end else begin
                    cls_cmd.kind = K_ALLOC;
                end
            end
            2'd1: begin
                cls_cmd.kind = free_ok ? K_FREE : K_QUERY;
            end
            default: begin
                cls_cmd.kind = K_QUERY;
            end
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls_cmd;
        end
    end

endmodule

// ===== rtl/sfha_back.sv =====
// ============================================================================
// Allocator back end
// Sequencer that walks chunk headers and free lists, and queues result words.
// ============================================================================
module sfha_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  sfha_pkg::t_cmd      i_cmd,
    input  logic [31:0]         i_heap_base,
    output logic                empty,
    input  logic                pop,
    output sfha_pkg::t_res      o_res
);
    import sfha_pkg::*;

    t_hdr         mem [WORDS];
    t_hdr         r_mq;
    logic         r_ih;
    t_hdr         r_iv;
    logic [2:0]   r_iw;

    t_state       r_st;
    t_state       n_st;
    t_state       r_ret;
    t_state       r_ret2;
    t_cmd         r_cmd;
    t_hdr         r_h;
    t_widx        r_ha;
    t_hdr         r_e;
    t_widx        r_ea;
    t_widx        r_la;
    t_fld         r_lf;
    t_link        r_lv;
    logic [LEN_W-1:0] r_size2;
    logic [FC_W-1:0]  r_fc;
    logic [31:0]  r_res;
    logic         r_stat;
    t_link        r_head [SIZE_CLASSES];

    t_res         r_oq [2];
    logic         r_owp;
    logic         r_orp;
    logic [1:0]   r_ocnt;

    t_hdr         rd;
    t_hdr         patched;
    logic         mem_we;
    t_widx        mem_wa;
    t_hdr         mem_wd;
    t_widx        mem_ra;
    logic         out_push;
    logic         out_pop;
    logic         out_full;

    logic [LEN_W-1:0] e_len;
    logic [CL_W-1:0]  e_cls;
    logic [WI+1:0]    e_diff;
    logic [CL_W-1:0]  found_cls;
    logic             found;
    logic             fits;
    t_widx            o2;
    t_hdr             h2;
    logic [31:0]      fc_ext;
    logic [16:0]      fb;

    assign rd = r_ih ? r_iv : r_mq;

    always_comb begin
        e_diff = {r_e.nxt - r_ea, 2'b00};
        e_len  = LEN_W'(e_diff) - LEN_W'(HDR_BYTES);
        e_cls  = f_list_class(e_len);
        fits   = ({1'b0, r_cmd.size_w, 2'b00} + 34'(MIN_BYTES)) <= 34'(e_len);
        o2     = r_ea + WI'(HDR_WORDS) + r_cmd.size_w[WI-1:0];
        h2       = '0;
        h2.nxt   = r_e.nxt;
        h2.prv   = r_ea;
        h2.live  = 1'b1;
        patched = rd;
        case (r_lf)
            F_PRV:   patched.prv   = r_lv[WI-1:0];
            F_FNEXT: patched.fnext = r_lv;
            F_FPREV: patched.fprev = r_lv;
            default: patched       = rd;
        endcase
    end

    // Lowest non-empty class at or above the starting class.
    always_comb begin
        found     = 1'b0;
        found_cls = '0;
        for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
            if (r_head[i] != '0 && 6'(i) >= r_cmd.cls) begin
                found     = 1'b1;
                found_cls = CL_W'(i);
            end
        end
    end

    always_comb begin
        fc_ext = {{(32 - FC_W){r_fc[FC_W-1]}}, r_fc};
        if (fc_ext[31]) begin
            fb = '0;
        end else if (fc_ext > 32'(FB_MAX)) begin
            fb = 17'(FB_MAX);
        end else begin
            fb = fc_ext[16:0];
        end
    end

    assign out_full = (r_ocnt == 2'd2);
    assign out_pop  = pop && !empty;
    assign empty    = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_orp];

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (i_cmd_valid && !out_full) begin
                    case (i_cmd.kind)
                        K_ALLOC: n_st = S_ALC_FIND;
                        K_FREE:  n_st = S_FR_RD;
                        default: n_st = S_DONE;
                    endcase
                end
            end
            S_ALC_FIND:  n_st = found ? S_ALC_RD : S_DONE;
            S_ALC_RD:    n_st = S_ALC_LD;
            S_ALC_LD:    n_st = S_UL0;
            S_ALC_SPLIT: n_st = fits ? S_RMW_RD : S_ALC_DONE;
            S_ALC_PUSH:  n_st = S_PU0;
            S_ALC_DONE:  n_st = S_DONE;
            S_UL0:       n_st = (r_e.fprev == '0) ? S_UL1 : S_RMW_RD;
            S_UL1:       n_st = (r_e.fnext != '0) ? S_RMW_RD : r_ret2;
            S_PU0:       n_st = (r_head[e_cls] != '0) ? S_RMW_RD : S_PU1;
            S_PU1:       n_st = r_ret2;
            S_RMW_RD:    n_st = S_RMW_WR;
            S_RMW_WR:    n_st = r_ret;
            S_FR_RD:     n_st = S_FR_CHK;
            S_FR_CHK:    n_st = (rd.live && rd.used) ? S_FR_XRD : S_DONE;
            S_FR_XRD:    n_st = S_FR_XCHK;
            S_FR_XCHK:   n_st = rd.used ? S_FR_PRD : S_UL0;
            S_FR_XM:     n_st = S_RMW_RD;
            S_FR_PRD:    n_st = S_FR_PCHK;
            S_FR_PCHK:   n_st = rd.used ? S_PU0 : S_UL0;
            S_FR_PM:     n_st = S_RMW_RD;
            S_FR_PPUSH:  n_st = S_PU0;
            S_DONE:      n_st = S_IDLE;
            default:     n_st = S_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        mem_ra    = '0;
        mem_we    = 1'b0;
        mem_wa    = r_ea;
        mem_wd    = r_e;
        o_cmd_pop = 1'b0;
        out_push  = 1'b0;
        case (r_st)
            S_IDLE:     o_cmd_pop = i_cmd_valid && !out_full;
            S_ALC_RD:   mem_ra = r_ea;
            S_RMW_RD:   mem_ra = r_la;
            S_FR_RD:    mem_ra = r_ha;
            S_FR_XRD:   mem_ra = r_h.nxt;
            S_FR_PRD:   mem_ra = r_h.prv;
            S_RMW_WR: begin
                mem_we = 1'b1;
                mem_wa = r_la;
                mem_wd = patched;
            end
            S_PU1: begin
                mem_we = 1'b1;
            end
            S_ALC_DONE: begin
                mem_we      = 1'b1;
                mem_wa      = r_ha;
                mem_wd      = r_h;
                mem_wd.used = 1'b1;
            end
            S_FR_XM: begin
                mem_we      = 1'b1;
                mem_wd.live = 1'b0;
            end
            S_FR_PM: begin
                mem_we      = 1'b1;
                mem_wa      = r_ha;
                mem_wd      = r_h;
                mem_wd.live = 1'b0;
                mem_wd.used = 1'b0;
            end
            S_DONE:     out_push = 1'b1;
            default:    mem_ra = '0;
        endcase
    end

    // Header store; the three reset chunks read from constants until first written.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mq <= mem[mem_ra];
        if (mem_ra == '0 && !r_iw[0]) begin
            r_ih <= 1'b1;
            r_iv <= f_init_hdr(2'd0);
        end else if (mem_ra == WI'(MIN_WORDS) && !r_iw[1]) begin
            r_ih <= 1'b1;
            r_iv <= f_init_hdr(2'd1);
        end else if (mem_ra == WI'(LAST_W) && !r_iw[2]) begin
            r_ih <= 1'b1;
            r_iv <= f_init_hdr(2'd2);
        end else begin
            r_ih <= 1'b0;
            r_iv <= r_mq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iw <= '0;
        end else if (mem_we) begin
            if (mem_wa == '0) begin
                r_iw[0] <= 1'b1;
            end
            if (mem_wa == WI'(MIN_WORDS)) begin
                r_iw[1] <= 1'b1;
            end
            if (mem_wa == WI'(LAST_W)) begin
                r_iw[2] <= 1'b1;
            end
        end
    end

    // Control state: sequencer state, list heads, free tally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fc <= FC_W'(INIT_FC);
            for (int i = 0; i < SIZE_CLASSES; i++) begin
                r_head[i] <= (CL_W'(i) == INIT_CLASS) ? LW'(MIN_WORDS + 1) : '0;
            end
        end else begin
            r_st <= n_st;
            case (r_st)
                S_UL0: begin
                    if (r_e.fprev == '0) begin
                        r_head[e_cls] <= r_e.fnext;
                    end
                end
                S_PU0: begin
                    r_head[e_cls] <= LW'(r_ea) + LW'(1);
                    r_fc          <= r_fc + FC_W'(e_len);
                end
                S_ALC_DONE: r_fc <= r_fc - FC_W'(r_size2);
                S_FR_XM:    r_fc <= r_fc + FC_W'(HDR_BYTES) - FC_W'(e_len);
                S_FR_PM:    r_fc <= r_fc + FC_W'(HDR_BYTES) - FC_W'(e_len);
                default:    r_fc <= r_fc;
            endcase
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_ha   <= i_cmd.off_w;
                r_stat <= (i_cmd.kind == K_FAIL);
                r_res  <= '0;
            end
            S_ALC_FIND: begin
                if (found) begin
                    r_ea <= WI'(r_head[found_cls] - LW'(1));
                end else begin
                    r_stat <= 1'b1;
                end
            end
            S_ALC_LD: begin
                r_e    <= rd;
                r_ret2 <= S_ALC_SPLIT;
            end
            S_UL0: begin
                r_la  <= WI'(r_e.fprev - LW'(1));
                r_lf  <= F_FNEXT;
                r_lv  <= r_e.fnext;
                r_ret <= S_UL1;
            end
            S_UL1: begin
                r_la    <= WI'(r_e.fnext - LW'(1));
                r_lf    <= F_FPREV;
                r_lv    <= r_e.fprev;
                r_ret   <= r_ret2;
                r_e.fnext <= '0;
                r_e.fprev <= '0;
            end
            S_ALC_SPLIT: begin
                r_h     <= r_e;
                r_ha    <= r_ea;
                r_size2 <= e_len;
                if (fits) begin
                    r_e     <= h2;
                    r_ea    <= o2;
                    r_h.nxt <= o2;
                    r_la    <= r_e.nxt;
                    r_lf    <= F_PRV;
                    r_lv    <= LW'(o2);
                    r_ret   <= S_ALC_PUSH;
                end
            end
            S_ALC_PUSH: r_ret2 <= S_ALC_DONE;
            S_PU0: begin
                r_e.fprev <= '0;
                r_e.fnext <= r_head[e_cls];
                r_la      <= WI'(r_head[e_cls] - LW'(1));
                r_lf      <= F_FPREV;
                r_lv      <= LW'(r_ea) + LW'(1);
                r_ret     <= S_PU1;
            end
            S_ALC_DONE: r_res <= i_heap_base + {{(30 - WI){1'b0}}, r_ha, 2'b00} +
                                 32'(HDR_BYTES);
            S_FR_CHK:   r_h  <= rd;
            S_FR_XRD:   r_ea <= r_h.nxt;
            S_FR_XCHK: begin
                r_e    <= rd;
                r_ret2 <= S_FR_XM;
            end
            S_FR_XM: begin
                r_h.nxt <= r_e.nxt;
                r_la    <= r_e.nxt;
                r_lf    <= F_PRV;
                r_lv    <= LW'(r_ha);
                r_ret   <= S_FR_PRD;
            end
            S_FR_PRD:   r_ea <= r_h.prv;
            S_FR_PCHK: begin
                if (!rd.used) begin
                    r_e    <= rd;
                    r_ret2 <= S_FR_PM;
                end else begin
                    r_e      <= r_h;
                    r_e.used <= 1'b0;
                    r_ea     <= r_ha;
                    r_ret2   <= S_DONE;
                end
            end
            S_FR_PM: begin
                r_e.nxt <= r_h.nxt;
                r_la    <= r_h.nxt;
                r_lf    <= F_PRV;
                r_lv    <= LW'(r_ea);
                r_ret   <= S_FR_PPUSH;
            end
            S_FR_PPUSH: r_ret2 <= S_DONE;
            default:    r_lv   <= r_lv;
        endcase
    end

    // Result queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(out_push) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_oq[r_owp] <= '{addr: r_res, status: r_stat, fb: fb};
        end
    end

endmodule

// ===== rtl/segregated_fit_heap_allocator.sv =====
// ============================================================================
// Segregated-fit heap allocator
// Power-of-two class free lists over a fixed region, with split and merge.
// ============================================================================
// The back end takes a new word only after it has queued the result of the last one,
// as its sequencer reads or writes one header of the header store per step; the
// front end queues up to two words in the meantime.
// Reset is synchronous and active low; it empties both queues, sets heap_base
// to 0 and lays out the initial three chunks at once, with no clearing pass.
module segregated_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_request_bytes,
    input  logic [31:0] i_block_address,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_result_address,
    output logic        o_status,
    output logic [16:0] o_free_bytes,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import sfha_pkg::*;

    logic [31:0] r_heap_base;
    logic        cmd_valid;
    logic        cmd_pop;
    t_cmd        cmd;
    t_res        res;

    // The user must write the base address only while no word is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (i_cfg_we) begin
            r_heap_base <= i_cfg_wdata;
        end
    end

    // Front end: classifies each request and queues it.
    sfha_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_operation     (i_operation),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .i_heap_base     (r_heap_base),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_pop       (cmd_pop),
        .o_cmd           (cmd)
    );

    // Back end: walks headers and lists, then queues the result word.
    sfha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .i_heap_base (r_heap_base),
        .empty       (empty),
        .pop         (pop),
        .o_res       (res)
    );

    assign o_result_address = res.addr;
    assign o_status         = res.status;
    assign o_free_bytes     = res.fb;

endmodule
